[sv/text_source_validator_unit_macros.svh]
// Assertion macros used by the checker of the text source validator.
`ifndef TEXT_SOURCE_VALIDATOR_UNIT_MACROS_SVH
`define TEXT_SOURCE_VALIDATOR_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and held off while arst_n is low.
`define TSV_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("text source validator check failed");

// Next-cycle implication, sampled on clk and held off while arst_n is low.
`define TSV_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("text source validator check failed");

`endif

[sv/tsv_pkg.sv]
// Shared types, constants and codes of the text source validator.
package tsv_pkg;

	localparam int COUNT_W   = 32;
	localparam int MAX_W     = 32;
	localparam int CMP_W     = (COUNT_W > MAX_W) ? COUNT_W : MAX_W;
	localparam int CTRL10_W  = COUNT_W + 4;

	localparam logic [MAX_W-1:0] MAX_RESET = MAX_W'(1048576);

	localparam logic [7:0] B_NUL = 8'h00;
	localparam logic [7:0] B_TAB = 8'h09;
	localparam logic [7:0] B_LF  = 8'h0A;
	localparam logic [7:0] B_CR  = 8'h0D;
	localparam logic [7:0] B_SP  = 8'h20;
	localparam logic [7:0] B_DEL = 8'h7F;
	localparam logic [7:0] B_EF  = 8'hEF;
	localparam logic [7:0] B_BB  = 8'hBB;
	localparam logic [7:0] B_BF  = 8'hBF;
	localparam logic [7:0] B_FE  = 8'hFE;
	localparam logic [7:0] B_FF  = 8'hFF;

	localparam logic [7:0] LEAD2_LO = 8'hC2;
	localparam logic [7:0] LEAD2_HI = 8'hDF;
	localparam logic [7:0] LEAD3_LO = 8'hE0;
	localparam logic [7:0] LEAD3_HI = 8'hEF;
	localparam logic [7:0] LEAD4_LO = 8'hF0;
	localparam logic [7:0] LEAD4_HI = 8'hF4;

	localparam logic [20:0] CP_MAX     = 21'h10FFFF;
	localparam logic [20:0] SURR_LO    = 21'h00D800;
	localparam logic [20:0] SURR_HI    = 21'h00DFFF;
	localparam logic [20:0] FLOOR_2B   = 21'h000080;
	localparam logic [20:0] FLOOR_3B   = 21'h000800;
	localparam logic [20:0] FLOOR_4B   = 21'h010000;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_TOO_LARGE = 3'd1,
		ST_MARK      = 3'd2,
		ST_BINARY    = 3'd3,
		ST_INVALID   = 3'd4
	} tsv_status_t;

	// One processing step; also the bit position in an operation mask.
	typedef enum logic [1:0] {
		OP_EF     = 2'd0,
		OP_BB     = 2'd1,
		OP_BYTE   = 2'd2,
		OP_STATUS = 2'd3
	} tsv_op_t;

	typedef logic [3:0] tsv_ops_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} tsv_in_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] out_byte;
		logic [2:0] status;
		logic       last;
	} tsv_out_t;

	// Stream facts settled when the last byte is taken in.
	typedef struct packed {
		logic               too_large;
		logic               mark_bad;
		logic [COUNT_W-1:0] stripped;
	} tsv_vinfo_t;

	typedef struct packed {
		tsv_ops_t   ops;
		tsv_vinfo_t vinfo;
	} tsv_plan_t;

endpackage

[sv/tsv_front.sv]
// Front end: byte count, header capture and leading mark detection.
module tsv_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      accept,
	input  tsv_pkg::tsv_in_t          req,
	input  logic [tsv_pkg::MAX_W-1:0] max_bytes,
	output tsv_pkg::tsv_plan_t        plan
);
	import tsv_pkg::*;

	logic [COUNT_W-1:0] total_q;
	logic [31:0]        header_q;
	logic [1:0]         held_q;
	logic               mark_q;

	logic [COUNT_W-1:0] total_n;
	logic [31:0]        header_n;
	logic [1:0]         held_n;
	logic               mark_n;
	logic               hold1;
	logic               hold2;
	logic               strip;
	logic [7:0]         ha;
	logic [7:0]         hb;
	logic               four_zero_mark;
	logic [7:0]         c;

	assign c = req.data_byte;

	always_comb begin
		total_n  = (&total_q) ? total_q : total_q + COUNT_W'(1);
		header_n = (total_q < COUNT_W'(4)) ? {header_q[23:0], c} : header_q;

		hold1 = (total_q == '0) && (c == B_EF) && !req.last_byte;
		hold2 = (total_q == COUNT_W'(1)) && (held_q == 2'd1) && (c == B_BB)
			&& !req.last_byte;
		strip = (total_q == COUNT_W'(2)) && (held_q == 2'd2) && (c == B_BF);

		plan.ops = '0;
		held_n   = 2'd0;
		if (hold1) begin
			held_n = 2'd1;
		end else if (hold2) begin
			held_n = 2'd2;
		end else if (strip) begin
			plan.ops[OP_STATUS] = req.last_byte;
		end else begin
			plan.ops[OP_EF]     = (held_q >= 2'd1);
			plan.ops[OP_BB]     = (held_q >= 2'd2);
			plan.ops[OP_BYTE]   = 1'b1;
			plan.ops[OP_STATUS] = req.last_byte;
		end
		mark_n = mark_q | strip;

		// The first two header bytes sit higher the more bytes have arrived.
		if (total_n >= COUNT_W'(4)) begin
			ha = header_n[31:24];
			hb = header_n[23:16];
		end else if (total_n == COUNT_W'(3)) begin
			ha = header_n[23:16];
			hb = header_n[15:8];
		end else begin
			ha = header_n[15:8];
			hb = header_n[7:0];
		end
		four_zero_mark = (total_n >= COUNT_W'(4)) && (ha == B_NUL) && (hb == B_NUL)
			&& (header_n[15:8] == B_FE) && (header_n[7:0] == B_FF);

		plan.vinfo.mark_bad = (total_n >= COUNT_W'(2)) &&
			(((ha == B_FE) && (hb == B_FF)) || ((ha == B_FF) && (hb == B_FE))
			|| four_zero_mark);
		plan.vinfo.too_large = CMP_W'(total_n) > CMP_W'(max_bytes);
		plan.vinfo.stripped  = (mark_n && (total_n >= COUNT_W'(3)))
			? total_n - COUNT_W'(3) : total_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q  <= '0;
			header_q <= '0;
			held_q   <= 2'd0;
			mark_q   <= 1'b0;
		end else if (accept) begin
			if (req.last_byte) begin
				total_q  <= '0;
				header_q <= '0;
				held_q   <= 2'd0;
				mark_q   <= 1'b0;
			end else begin
				total_q  <= total_n;
				header_q <= header_n;
				held_q   <= held_n;
				mark_q   <= mark_n;
			end
		end
	end

endmodule

[sv/tsv_core.sv]
// Byte processor: control counting, UTF-8 decoding, line-end folding, verdict.
module tsv_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  tsv_pkg::tsv_op_t    op,
	input  logic [7:0]          data_byte,
	input  tsv_pkg::tsv_vinfo_t vinfo,
	output logic                emit,
	output tsv_pkg::tsv_out_t   rsp
);
	import tsv_pkg::*;

	logic [COUNT_W-1:0] ctrl_q;
	logic               nul_q;
	logic [1:0]         cont_q;
	logic [20:0]        acc_q;
	logic [1:0]         floor_q;
	logic               err_q;
	logic               cr_q;

	logic [COUNT_W-1:0] ctrl_n;
	logic               nul_n;
	logic [1:0]         cont_n;
	logic [20:0]        acc_n;
	logic [1:0]         floor_n;
	logic               err_n;
	logic               cr_n;

	logic [7:0]          c;
	logic                is_ctrl;
	logic [20:0]         floor_val;
	logic [20:0]         acc_shift;
	logic [CTRL10_W-1:0] ctrl_ext;
	logic [CTRL10_W-1:0] ctrl10;
	logic                binary;
	tsv_status_t         verdict;

	always_comb begin
		case (op)
			OP_EF:   c = B_EF;
			OP_BB:   c = B_BB;
			default: c = data_byte;
		endcase
	end

	always_comb begin
		case (floor_q)
			2'd1:    floor_val = FLOOR_2B;
			2'd2:    floor_val = FLOOR_3B;
			default: floor_val = FLOOR_4B;
		endcase
	end

	assign is_ctrl   = ((c < B_SP) && (c != B_TAB) && (c != B_LF) && (c != B_CR))
		|| (c == B_DEL);
	assign acc_shift = {acc_q[14:0], c[5:0]};

	// Binary when a NUL was seen or ten times the control count exceeds the stripped length.
	assign ctrl_ext = CTRL10_W'(ctrl_q);
	assign ctrl10   = (ctrl_ext << 3) + (ctrl_ext << 1);
	assign binary   = nul_q || (ctrl10 > CTRL10_W'(vinfo.stripped));

	always_comb begin
		if (vinfo.too_large) begin
			verdict = ST_TOO_LARGE;
		end else if (vinfo.mark_bad) begin
			verdict = ST_MARK;
		end else if (binary) begin
			verdict = ST_BINARY;
		end else if (err_q || (cont_q != 2'd0)) begin
			verdict = ST_INVALID;
		end else begin
			verdict = ST_OK;
		end
	end

	always_comb begin
		ctrl_n  = ctrl_q;
		nul_n   = nul_q;
		cont_n  = cont_q;
		acc_n   = acc_q;
		floor_n = floor_q;
		err_n   = err_q;
		cr_n    = cr_q;
		emit    = 1'b0;
		rsp     = '0;

		if (op == OP_STATUS) begin
			emit       = 1'b1;
			rsp.kind   = 1'b1;
			rsp.status = verdict;
			rsp.last   = 1'b1;
			ctrl_n     = '0;
			nul_n      = 1'b0;
			cont_n     = 2'd0;
			acc_n      = '0;
			floor_n    = 2'd0;
			err_n      = 1'b0;
			cr_n       = 1'b0;
		end else begin
			if (c == B_NUL) begin
				nul_n = 1'b1;
			end
			if (is_ctrl && !(&ctrl_q)) begin
				ctrl_n = ctrl_q + COUNT_W'(1);
			end

			if (cont_q == 2'd0) begin
				if (c[7]) begin
					if ((c >= LEAD2_LO) && (c <= LEAD2_HI)) begin
						acc_n   = {16'd0, c[4:0]};
						cont_n  = 2'd1;
						floor_n = 2'd1;
					end else if ((c >= LEAD3_LO) && (c <= LEAD3_HI)) begin
						acc_n   = {17'd0, c[3:0]};
						cont_n  = 2'd2;
						floor_n = 2'd2;
					end else if ((c >= LEAD4_LO) && (c <= LEAD4_HI)) begin
						acc_n   = {18'd0, c[2:0]};
						cont_n  = 2'd3;
						floor_n = 2'd3;
					end else begin
						err_n = 1'b1;
					end
				end
			end else if (c[7:6] != 2'b10) begin
				// A broken sequence restarts decoding at the next byte.
				err_n  = 1'b1;
				cont_n = 2'd0;
			end else begin
				acc_n  = acc_shift;
				cont_n = cont_q - 2'd1;
				if (cont_q == 2'd1) begin
					if ((acc_shift < floor_val) || (acc_shift > CP_MAX) ||
						((acc_shift >= SURR_LO) && (acc_shift <= SURR_HI))) begin
						err_n = 1'b1;
					end
					floor_n = 2'd0;
				end
			end

			// CR becomes LF, and an LF right after a CR is dropped.
			if (c == B_CR) begin
				cr_n         = 1'b1;
				emit         = 1'b1;
				rsp.out_byte = B_LF;
			end else if ((c == B_LF) && cr_q) begin
				cr_n = 1'b0;
			end else begin
				cr_n         = 1'b0;
				emit         = 1'b1;
				rsp.out_byte = c;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q  <= '0;
			nul_q   <= 1'b0;
			cont_q  <= 2'd0;
			acc_q   <= '0;
			floor_q <= 2'd0;
			err_q   <= 1'b0;
			cr_q    <= 1'b0;
		end else if (step) begin
			ctrl_q  <= ctrl_n;
			nul_q   <= nul_n;
			cont_q  <= cont_n;
			acc_q   <= acc_n;
			floor_q <= floor_n;
			err_q   <= err_n;
			cr_q    <= cr_n;
		end
	end

endmodule

[sv/text_source_validator_unit.sv]
// Top level of the text source validator: input stage, step sequencing, result register.
//
//   Channel   Direction  Handshake            Payload
//   in        request    in_valid / in_stall  in_req  (data_byte, last_byte)
//   out       result     out_valid / out_stall out_rsp (kind, out_byte, status, last)
//   cfg       write      cfg_we               cfg_wdata (max_source_bytes)
//
// An ordinary byte is taken into the input stage while the previous one goes through
// the byte processor into the result register.
// A request stays in the input stage until it has run every processing step it needs: a
// last byte needs two (its text and the status), and a byte that releases held mark
// bytes needs one more for each of them, at most two; a held mark byte needs none, and
// the byte that completes a stripped mark needs one only when it is last (the status).
// The single result register takes one result per cycle unless out_stall holds it full.
// While out_stall holds a full result register, the processor halts, and in_stall rises
// once the input stage is occupied. Reset (arst_n low) clears all stream state and sets
// max_source_bytes to 1048576; no clearing pass follows.
module text_source_validator_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [tsv_pkg::MAX_W-1:0] cfg_wdata,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  tsv_pkg::tsv_in_t          in_req,
	output logic                      out_valid,
	input  logic                      out_stall,
	output tsv_pkg::tsv_out_t         out_rsp
);
	import tsv_pkg::*;

	logic [MAX_W-1:0] max_q;

	// Input stage: the remaining processing steps of one request.
	tsv_ops_t   ops_s1;
	logic [7:0] byte_s1;
	tsv_vinfo_t vinfo_s1;

	logic     out_valid_q;
	tsv_out_t out_q;

	logic      in_accept;
	tsv_plan_t plan;
	tsv_op_t   cur_op;
	tsv_ops_t  rest_ops;
	logic      out_free;
	logic      step;
	logic      emit;
	tsv_out_t  core_rsp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= MAX_RESET;
		end else if (cfg_we) begin
			max_q <= cfg_wdata;
		end
	end

	tsv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (in_accept),
		.req       (in_req),
		.max_bytes (max_q),
		.plan      (plan)
	);

	// Steps run in stream order: held EF, held BB, the byte itself, then the status.
	always_comb begin
		if (ops_s1[OP_EF]) begin
			cur_op = OP_EF;
		end else if (ops_s1[OP_BB]) begin
			cur_op = OP_BB;
		end else if (ops_s1[OP_BYTE]) begin
			cur_op = OP_BYTE;
		end else begin
			cur_op = OP_STATUS;
		end
		rest_ops         = ops_s1;
		rest_ops[cur_op] = 1'b0;
	end

	// A step runs only when its result, if any, has somewhere to go.
	assign out_free  = !out_valid_q || !out_stall;
	assign step      = (ops_s1 != '0) && out_free;
	assign in_stall  = (ops_s1 != '0) && !(step && (rest_ops == '0));
	assign in_accept = in_valid && !in_stall;

	tsv_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.op        (cur_op),
		.data_byte (byte_s1),
		.vinfo     (vinfo_s1),
		.emit      (emit),
		.rsp       (core_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ops_s1 <= '0;
		end else if (in_accept) begin
			ops_s1 <= plan.ops;
		end else if (step) begin
			ops_s1 <= rest_ops;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			byte_s1  <= in_req.data_byte;
			vinfo_s1 <= plan.vinfo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			out_q <= core_rsp;
		end
	end

	assign out_valid = out_valid_q;
	assign out_rsp   = out_q;

endmodule

[sv/tsv_checker.sv]
// Port-level checker of the text source validator and its bind statement.
`include "text_source_validator_unit_macros.svh"

module tsv_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_stall,
	input logic                      out_valid,
	input logic                      out_stall,
	input tsv_pkg::tsv_out_t         out_rsp
);
	import tsv_pkg::*;

	// A status item carries no text byte and always closes the stream.
	`TSV_ASSERT_NOW(a_status_closes, out_valid && out_rsp.kind, out_rsp.last && out_rsp.out_byte == B_NUL)

	// A text item never closes the stream and carries no status.
	`TSV_ASSERT_NOW(a_text_plain, out_valid && !out_rsp.kind, !out_rsp.last && out_rsp.status == ST_OK)

	// Only defined status codes appear.
	`TSV_ASSERT_NOW(a_status_code, out_valid && out_rsp.kind, out_rsp.status <= ST_INVALID)

	// A stalled result stays in place.
	`TSV_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_rsp))

	// With no request arriving, an open input never closes again on its own.
	`TSV_ASSERT_NEXT(a_in_open, !in_valid && !in_stall, !in_stall)

endmodule

bind text_source_validator_unit tsv_checker u_tsv_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_rsp   (out_rsp)
);

[dv/tb.sv]
// Self-checking testbench of the text source validator: directed streams, then random streams.
module tb;
	import tsv_pkg::*;

	// The run is cut off here whatever happens; the slowest clean run is far shorter.
	localparam int CYCLE_LIMIT = 200000;
	// Quiet cycles after the last expected result before a register write or the end.
	localparam int SETTLE_CYCLES = 8;
	// Fewest random bytes sent in each idling phase.
	localparam int PHASE_BYTES = 22;
	localparam logic [COUNT_W-1:0] COUNT_TOP = '1;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [MAX_W-1:0]  cfg_wdata = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	tsv_in_t           in_req = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	tsv_out_t          out_rsp;

	// Mirror of the block's stream state, updated as requests are accepted.
	logic [COUNT_W-1:0] seen_total;
	logic [COUNT_W-1:0] ctrl_total;
	logic [31:0]        head_word;
	logic [1:0]         held_count;
	logic               mark_gone;
	logic               nul_hit;
	logic [1:0]         cont_left;
	logic [20:0]        code_acc;
	logic [1:0]         floor_sel;
	logic               utf_bad;
	logic               cr_pending;
	logic [MAX_W-1:0]   size_limit;

	// Results still owed by the block, oldest first.
	tsv_out_t    expected_items[$];
	tsv_out_t    oldest_item;
	logic [7:0]  stream_bytes[$];
	int          error_count = 0;
	int          cycle_count = 0;
	int          tx_idle_pct = 0;
	int          rx_idle_pct = 0;
	int          phase_bytes = 0;

	text_source_validator_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_req    (in_req),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_rsp   (out_rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	// The receiver stalls at random, driven at the falling edge like every other input.
	always @(negedge clk) begin
		out_stall <= (rx_idle_pct != 0) && ($urandom_range(0, 99) < rx_idle_pct);
	end

	function automatic void clear_stream_state();
		seen_total = '0;
		ctrl_total = '0;
		head_word = '0;
		held_count = '0;
		mark_gone = 1'b0;
		nul_hit = 1'b0;
		cont_left = '0;
		code_acc = '0;
		floor_sel = '0;
		utf_bad = 1'b0;
		cr_pending = 1'b0;
	endfunction

	function automatic void owe_result(input logic is_status, input logic [7:0] b,
			input tsv_status_t st);
		tsv_out_t r;
		r.kind = is_status;
		r.out_byte = b;
		r.status = st;
		r.last = is_status;
		expected_items = {expected_items, r};
	endfunction

	// One byte of the text after the mark has been stripped: it is counted for the
	// binary test, run through the UTF-8 decoder, and then emitted with line endings
	// folded to LF.
	function automatic void take_text_byte(input logic [7:0] c);
		logic [20:0] floor_cp;
		if (c == B_NUL)
			nul_hit = 1'b1;
		if (((c < B_SP) && (c != B_TAB) && (c != B_LF) && (c != B_CR)) || (c == B_DEL)) begin
			if (ctrl_total != COUNT_TOP)
				ctrl_total = ctrl_total + 1'b1;
		end

		if (cont_left == 0) begin
			// A fresh lead byte: ASCII passes, the three lead ranges open a sequence,
			// and anything else with the top bit set is an illegal lead.
			if (c >= LEAD2_LO && c <= LEAD2_HI) begin
				code_acc = {16'b0, c[4:0]};
				cont_left = 2'd1;
				floor_sel = 2'd1;
			end else if (c >= LEAD3_LO && c <= LEAD3_HI) begin
				code_acc = {17'b0, c[3:0]};
				cont_left = 2'd2;
				floor_sel = 2'd2;
			end else if (c >= LEAD4_LO && c <= LEAD4_HI) begin
				code_acc = {18'b0, c[2:0]};
				cont_left = 2'd3;
				floor_sel = 2'd3;
			end else if (c[7]) begin
				utf_bad = 1'b1;
			end
		end else if (c[7:6] != 2'b10) begin
			// A missing continuation marks the stream bad and decoding restarts with
			// the next byte, not this one.
			utf_bad = 1'b1;
			cont_left = '0;
		end else begin
			code_acc = {code_acc[14:0], c[5:0]};
			cont_left = cont_left - 1'b1;
			if (cont_left == 0) begin
				floor_cp = (floor_sel == 2'd1) ? FLOOR_2B :
					(floor_sel == 2'd2) ? FLOOR_3B : FLOOR_4B;
				if (code_acc < floor_cp || code_acc > CP_MAX ||
						(code_acc >= SURR_LO && code_acc <= SURR_HI))
					utf_bad = 1'b1;
				floor_sel = '0;
			end
		end

		if (c == B_CR) begin
			cr_pending = 1'b1;
			owe_result(1'b0, B_LF, ST_OK);
		end else if (c == B_LF && cr_pending) begin
			cr_pending = 1'b0;
		end else begin
			cr_pending = 1'b0;
			owe_result(1'b0, c, ST_OK);
		end
	endfunction

	// Works out every result that one accepted request causes and queues it.
	function automatic void predict_text_results(input logic [7:0] c, input logic is_last);
		logic [COUNT_W-1:0] pos;
		logic [31:0]        lead_word;
		logic [63:0]        stripped_len;
		logic               wide_mark;
		tsv_status_t        verdict;
		int                 n;
		pos = seen_total;
		if (pos < 4)
			head_word = {head_word[23:0], c};
		if (seen_total != COUNT_TOP)
			seen_total = seen_total + 1'b1;

		// The first bytes of a possible EF BB BF are held back; the third one either
		// completes the mark or releases what was held ahead of itself.
		if (pos == 0 && c == B_EF && !is_last) begin
			held_count = 2'd1;
		end else if (pos == 1 && held_count == 2'd1 && c == B_BB && !is_last) begin
			held_count = 2'd2;
		end else if (pos == 2 && held_count == 2'd2 && c == B_BF) begin
			held_count = '0;
			mark_gone = 1'b1;
		end else begin
			if (held_count >= 2'd1)
				take_text_byte(B_EF);
			if (held_count >= 2'd2)
				take_text_byte(B_BB);
			held_count = '0;
			take_text_byte(c);
		end

		if (is_last) begin
			n = (seen_total < 4) ? int'(seen_total) : 4;
			// Left-align the first bytes of the stream so that the first one sits at the top.
			lead_word = head_word << (8 * (4 - n));
			wide_mark = (n >= 2) &&
				((lead_word[31:24] == B_FE && lead_word[23:16] == B_FF) ||
				 (lead_word[31:24] == B_FF && lead_word[23:16] == B_FE));
			if (n == 4 && lead_word == {B_NUL, B_NUL, B_FE, B_FF})
				wide_mark = 1'b1;
			stripped_len = 64'(seen_total);
			if (mark_gone && stripped_len >= 3)
				stripped_len = stripped_len - 3;

			if (seen_total > size_limit)
				verdict = ST_TOO_LARGE;
			else if (wide_mark)
				verdict = ST_MARK;
			else if (nul_hit || (64'(ctrl_total) * 10 > stripped_len))
				verdict = ST_BINARY;
			else if (utf_bad || cont_left != 0)
				verdict = ST_INVALID;
			else
				verdict = ST_OK;
			owe_result(1'b1, 8'h00, verdict);
			clear_stream_state();
		end
	endfunction

	// Everything is observed at the rising edge in one place: register writes and
	// accepted requests update the prediction before results are checked, so the
	// order in which processes wake up within the edge does not matter.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				size_limit = cfg_wdata;
			if (in_valid && !in_stall)
				predict_text_results(in_req.data_byte, in_req.last_byte);
			if (out_valid && !out_stall) begin
				if (expected_items.size() == 0) begin
					$display("%0t: unexpected result, actual kind=%0d byte=%h status=%0d last=%0d",
						$time, out_rsp.kind, out_rsp.out_byte, out_rsp.status, out_rsp.last);
					error_count++;
				end else begin
					oldest_item = expected_items.pop_front();
					if (out_rsp.kind !== oldest_item.kind ||
							out_rsp.out_byte !== oldest_item.out_byte ||
							out_rsp.status !== oldest_item.status ||
							out_rsp.last !== oldest_item.last) begin
						$display("%0t: mismatch, expected kind=%0d byte=%h status=%0d last=%0d, actual kind=%0d byte=%h status=%0d last=%0d",
							$time, oldest_item.kind, oldest_item.out_byte,
							oldest_item.status, oldest_item.last, out_rsp.kind,
							out_rsp.out_byte, out_rsp.status, out_rsp.last);
						error_count++;
					end
				end
			end
		end
	end

	// Sends one request: an optional random gap first, then valid stays up with a
	// steady payload until the block takes it. Valid is left high on return so that
	// back-to-back requests need no extra edge.
	task automatic send_byte(input logic [7:0] b, input logic is_last);
		int gaps;
		gaps = 0;
		while (($urandom_range(0, 99) < tx_idle_pct) && gaps < 20)
			gaps++;
		@(negedge clk);
		if (gaps > 0) begin
			in_valid <= 1'b0;
			repeat (gaps) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_req <= '{data_byte: b, last_byte: is_last};
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Sends the bytes collected in stream_bytes as one stream, the final one marked last.
	task automatic send_stream();
		for (int i = 0; i < stream_bytes.size(); i++)
			send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
		phase_bytes += stream_bytes.size();
		stream_bytes.delete();
	endtask

	// Drops valid, waits for every owed result, then for SETTLE_CYCLES quiet cycles.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_items.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic [MAX_W-1:0] value);
		settle();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Appends one byte to the stream being built.
	function automatic void add_byte(input logic [7:0] b);
		stream_bytes = {stream_bytes, b};
	endfunction

	function automatic void push_utf8(input logic [20:0] cp);
		if (cp < FLOOR_3B) begin
			add_byte({3'b110, cp[10:6]});
		end else if (cp < FLOOR_4B) begin
			add_byte({4'b1110, cp[15:12]});
			add_byte({2'b10, cp[11:6]});
		end else begin
			add_byte({5'b11110, cp[20:18]});
			add_byte({2'b10, cp[17:12]});
			add_byte({2'b10, cp[11:6]});
		end
		add_byte({2'b10, cp[5:0]});
	endfunction

	// Builds and sends one random stream. Half the streams are well-formed text with random
	// content so that decoding, stripping and line folding are exercised in depth; the
	// rest start with a byte-order mark of some kind, are corrupted, or are pure noise.
	task automatic random_stream();
		int          shape;
		int          len;
		int          pick;
		int          cut;
		logic [20:0] cp;
		shape = $urandom_range(0, 9);
		if (shape < 6) begin
			if ($urandom_range(0, 9) < 3) begin
				add_byte(B_EF);
				add_byte(B_BB);
				add_byte(B_BF);
			end
			len = $urandom_range(1, 12);
			repeat (len) begin
				pick = $urandom_range(0, 39);
				case (pick)
					0: add_byte(B_CR);
					1: add_byte(B_LF);
					2: begin
						add_byte(B_CR);
						add_byte(B_LF);
					end
					3: add_byte(B_TAB);
					4: add_byte(($urandom_range(0, 1) != 0) ? B_DEL :
						8'($urandom_range(1, 31)));
					5, 6, 7: push_utf8(21'($urandom_range(21'h80, 21'h7FF)));
					8, 9: begin
						cp = 21'($urandom_range(21'h800, 21'hFFFF));
						// Keep clear of the surrogate range in well-formed text.
						if (cp >= SURR_LO && cp <= SURR_HI)
							cp = cp - 21'h1000;
						push_utf8(cp);
					end
					10, 11: push_utf8(21'($urandom_range(21'h10000, 21'h10FFFF)));
					default: add_byte(8'($urandom_range(8'h20, 8'h7E)));
				endcase
			end
			// One shape in six breaks the text: a stray high byte, or a cut-off end.
			if (shape == 5) begin
				cut = $urandom_range(0, stream_bytes.size() - 1);
				if ($urandom_range(0, 1) != 0)
					stream_bytes[cut] = 8'($urandom_range(8'h80, 8'hFF));
				else if (stream_bytes.size() > 1)
					stream_bytes.delete(stream_bytes.size() - 1);
			end
		end else if (shape < 8) begin
			case ($urandom_range(0, 4))
				0: stream_bytes = '{B_EF, B_BB, B_BF};
				1: stream_bytes = '{B_FE, B_FF};
				2: stream_bytes = '{B_FF, B_FE};
				3: stream_bytes = '{B_NUL, B_NUL, B_FE, B_FF};
				default: stream_bytes = '{B_EF, B_BB};
			endcase
			repeat ($urandom_range(0, 3))
				add_byte(8'($urandom_range(8'h20, 8'h7E)));
		end else begin
			repeat ($urandom_range(1, 10))
				add_byte(8'($urandom_range(0, 255)));
		end
		send_stream();
	endtask

	// A stripped mark followed by CRLF and a lone CR at the end, then a mark prefix
	// cut short by the end of the stream, whose held bytes must come out as text.
	task automatic test_mark_and_line_ends();
		stream_bytes = '{B_EF, B_BB, B_BF, B_CR, B_LF, B_CR};
		send_stream();
		stream_bytes = '{B_EF, B_BB};
		send_stream();
	endtask

	// UTF-16 little-endian and UTF-32 big-endian marks are refused.
	task automatic test_wide_marks();
		stream_bytes = '{B_FF, B_FE};
		send_stream();
		stream_bytes = '{B_NUL, B_NUL, B_FE, B_FF};
		send_stream();
	endtask

	// A NUL on its own, and a stream made only of a control byte.
	task automatic test_binary();
		stream_bytes = '{B_NUL};
		send_stream();
		stream_bytes = '{B_DEL};
		send_stream();
	endtask

	// Illegal lead, overlong form, surrogate, code point above the top, and a sequence
	// left open by the end of the stream.
	task automatic test_utf8_errors();
		stream_bytes = '{8'hC0};
		send_stream();
		stream_bytes = '{LEAD3_LO, 8'h80, 8'h80};
		send_stream();
		stream_bytes = '{8'hED, 8'hA0, 8'h80};
		send_stream();
		stream_bytes = '{LEAD4_HI, 8'h90, 8'h80, 8'h80};
		send_stream();
		stream_bytes = '{8'hC3};
		send_stream();
	endtask

	// With the limit at zero every stream is too large; at the top nothing is.
	task automatic test_size_limit();
		write_limit('0);
		stream_bytes = '{8'h41};
		send_stream();
		write_limit('1);
		stream_bytes = '{8'h41};
		send_stream();
	endtask

	// Three phases of random streams: sender rarely idle and receiver mostly stalled,
	// then the reverse, then full speed on both sides. Each phase has its own limit.
	task automatic test_random();
		phase_bytes = 0;
		while (phase_bytes < PHASE_BYTES)
			random_stream();

		write_limit(MAX_W'($urandom_range(3, 12)));
		tx_idle_pct = 71;
		rx_idle_pct = 27;
		phase_bytes = 0;
		while (phase_bytes < PHASE_BYTES)
			random_stream();

		write_limit(MAX_RESET);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		phase_bytes = 0;
		while (phase_bytes < PHASE_BYTES)
			random_stream();
	endtask

	initial begin
		size_limit = MAX_RESET;
		clear_stream_state();
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		tx_idle_pct = 27;
		rx_idle_pct = 71;
		test_mark_and_line_ends();
		test_wide_marks();
		test_binary();
		test_utf8_errors();
		test_size_limit();
		test_random();

		settle();
		if (error_count == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
